### hw/rtl/lzwd_pkg.sv
// Package with the beat types, codes and control types of the LZW image decoder.
package lzwd_pkg;

    localparam logic [2:0]  ST_PIXEL     = 3'd0;
    localparam logic [2:0]  ST_NEED_BYTE = 3'd1;
    localparam logic [2:0]  ST_END       = 3'd2;
    localparam logic [2:0]  ST_ACCEPTED  = 3'd3;
    localparam logic [2:0]  ST_REJECTED  = 3'd4;

    localparam logic        OP_PUSH      = 1'b0;
    localparam logic        OP_PULL      = 1'b1;

    localparam logic [11:0] RESTART_CODE = 12'd256;
    localparam logic [11:0] END_CODE     = 12'd257;
    localparam logic [12:0] FIRST_FREE   = 13'd258;
    localparam logic [3:0]  START_WIDTH  = 4'd9;
    localparam int          STACK_DEPTH  = 4096;
    localparam logic [4:0]  RES_LIMIT    = 5'd16;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } req_beat_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] pixel;
    } rsp_beat_t;

    typedef struct packed {
        logic [11:0] prefix;
        logic [7:0]  suffix;
    } tbl_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK_RD,
        S_WALK_CHK,
        S_PUSH_RD,
        S_PUSH_WR,
        S_POP_RD,
        S_RESP
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_PUSH_BYTE,
        CMD_RESP_END,
        CMD_RESP_NEED,
        CMD_TAKE_CODE,
        CMD_WALK_RD,
        CMD_WALK_STEP,
        CMD_ADD,
        CMD_STR_RD,
        CMD_STR_WR,
        CMD_POP,
        CMD_LOAD_OUT
    } cmd_t;

    typedef struct packed {
        logic stack_empty;
        logic ended;
        logic short_bits;
        logic after_clear;
        logic code_end;
        logic code_clear;
        logic walk_more;
        logic push_more;
        logic out_free;
    } dp_status_t;

endpackage

### hw/rtl/lzw_image_decoder.sv
// Top level of the LZW image decoder.
//
// Channel  Direction  Beat            Handshake
// req      in         op, data_byte   req_valid / req_stall
// rsp      out        status, pixel   rsp_valid / rsp_stall
//
// A push beat goes through the response state to the output register. A pull that pops
// a stored pixel goes through the decide, pop-read and response states. A pull that
// decodes adds a decide per code read, a walk read and check per table read of the prefix
// walk (one more read than chain steps), and a read and stack write per stacked pixel.
// Reset clears all control state at once; the code table needs no clearing pass.
// The next request beat is taken once the result has entered the output register.
module lzw_image_decoder #(
    parameter int TABLE_DEPTH    = 4096,
    parameter int MAX_CODE_WIDTH = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  lzwd_pkg::req_beat_t req_beat,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output lzwd_pkg::rsp_beat_t rsp_beat
);
    import lzwd_pkg::*;

    cmd_t       cmd;
    dp_status_t st;

    lzwd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (req_beat.op),
        .st        (st),
        .req_stall (req_stall),
        .cmd       (cmd)
    );

    lzwd_datapath #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .MAX_CODE_WIDTH (MAX_CODE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req_beat  (req_beat),
        .rsp_stall (rsp_stall),
        .st        (st),
        .rsp_valid (rsp_valid),
        .rsp_beat  (rsp_beat)
    );

endmodule

### hw/rtl/lzwd_ctrl.sv
// Controller state machine of the LZW image decoder.
module lzwd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_op,
    input  lzwd_pkg::dp_status_t st,
    output logic                req_stall,
    output lzwd_pkg::cmd_t      cmd
);
    import lzwd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req_op == OP_PULL) ? S_DECIDE : S_RESP;
                end
            end
            S_DECIDE:
            begin
                if (!st.stack_empty)
                begin
                    state_next = S_POP_RD;
                end
                else if (st.ended || st.short_bits)
                begin
                    state_next = S_RESP;
                end
                else if (st.after_clear)
                begin
                    state_next = S_PUSH_RD;
                end
                else if (st.code_end)
                begin
                    state_next = S_RESP;
                end
                else if (st.code_clear)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD:  state_next = S_WALK_CHK;
            S_WALK_CHK: state_next = st.walk_more ? S_WALK_RD : S_PUSH_RD;
            S_PUSH_RD:  state_next = S_PUSH_WR;
            S_PUSH_WR:  state_next = st.push_more ? S_PUSH_RD : S_DECIDE;
            S_POP_RD:   state_next = S_RESP;
            S_RESP:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = CMD_NONE;
        req_stall = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_op == OP_PUSH)
                begin
                    cmd = CMD_PUSH_BYTE;
                end
            end
            S_DECIDE:
            begin
                if (!st.stack_empty)
                begin
                    cmd = CMD_NONE;
                end
                else if (st.ended)
                begin
                    cmd = CMD_RESP_END;
                end
                else if (st.short_bits)
                begin
                    cmd = CMD_RESP_NEED;
                end
                else
                begin
                    cmd = CMD_TAKE_CODE;
                end
            end
            S_WALK_RD:  cmd = CMD_WALK_RD;
            S_WALK_CHK: cmd = st.walk_more ? CMD_WALK_STEP : CMD_ADD;
            S_PUSH_RD:  cmd = CMD_STR_RD;
            S_PUSH_WR:  cmd = CMD_STR_WR;
            S_POP_RD:   cmd = CMD_POP;
            S_RESP:
            begin
                if (st.out_free)
                begin
                    cmd = CMD_LOAD_OUT;
                end
            end
            default:    cmd = CMD_NONE;
        endcase
    end

endmodule

### hw/rtl/lzwd_datapath.sv
// Datapath of the LZW image decoder: bit reservoir, code table, string stack and output register.
module lzwd_datapath #(
    parameter int TABLE_DEPTH    = 4096,
    parameter int MAX_CODE_WIDTH = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lzwd_pkg::cmd_t       cmd,
    input  lzwd_pkg::req_beat_t  req_beat,
    input  logic                 rsp_stall,
    output lzwd_pkg::dp_status_t st,
    output logic                 rsp_valid,
    output lzwd_pkg::rsp_beat_t  rsp_beat
);
    import lzwd_pkg::*;

    localparam int          AW       = $clog2(TABLE_DEPTH);
    localparam int          SW       = AW + 1;
    localparam logic [12:0] TD13     = 13'(TABLE_DEPTH);
    localparam logic [SW-1:0] TD_STEPS = SW'(TABLE_DEPTH);
    localparam logic [3:0]  MAXW     = 4'(MAX_CODE_WIDTH);
    localparam logic [12:0] STK_LAST = 13'(STACK_DEPTH - 1);

    logic [23:0]   res_reg, res_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [3:0]    width_reg, width_next;
    logic [12:0]   nfc_reg, nfc_next;
    logic [12:0]   hwm_reg, hwm_next;
    logic [11:0]   prev_reg, prev_next;
    logic          ac_reg, ac_next;
    logic          ended_reg, ended_next;
    logic [12:0]   stk_cnt_reg, stk_cnt_next;
    logic [11:0]   root_reg, root_next;
    logic [SW-1:0] steps_reg, steps_next;
    logic [11:0]   code_reg, code_next;
    logic [11:0]   cur_reg, cur_next;
    logic          ent_valid_reg, ent_valid_next;
    logic [2:0]    resp_reg, resp_next;
    logic          out_valid_reg, out_valid_next;
    rsp_beat_t     out_beat_reg, out_beat_next;

    tbl_entry_t    tbl_mem [TABLE_DEPTH];
    tbl_entry_t    tbl_rd_reg;
    logic [7:0]    stack_mem [STACK_DEPTH];
    logic [7:0]    stk_rd_reg;

    logic [11:0]   code_mask;
    logic [11:0]   code;
    logic [11:0]   tbl_addr;
    logic          tbl_wr;
    tbl_entry_t    tbl_wdata;
    logic [7:0]    root_char;
    logic [7:0]    str_char;

    function automatic logic is_entry(input logic [11:0] idx, input logic [12:0] hwm);
        is_entry = ({1'b0, idx} >= FIRST_FREE) && ({1'b0, idx} < hwm);
    endfunction

    assign code_mask = 12'((13'd1 << width_reg) - 13'd1);
    assign code      = res_reg[11:0] & code_mask;
    assign tbl_addr  = (cmd == CMD_WALK_RD) ? root_reg : cur_reg;
    assign root_char = ent_valid_reg ? tbl_rd_reg.suffix : root_reg[7:0];
    assign str_char  = ent_valid_reg ? tbl_rd_reg.suffix : cur_reg[7:0];
    assign tbl_wr    = (cmd == CMD_ADD) && (nfc_reg < TD13);
    assign tbl_wdata = '{prefix: prev_reg, suffix: root_char};

    always_comb
    begin
        st.stack_empty = (stk_cnt_reg == 13'd0);
        st.ended       = ended_reg;
        st.short_bits  = (cnt_reg < {1'b0, width_reg});
        st.after_clear = ac_reg;
        st.code_end    = (code == END_CODE);
        st.code_clear  = (code == RESTART_CODE);
        st.walk_more   = ent_valid_reg && (steps_reg < TD_STEPS);
        st.push_more   = ent_valid_reg && (stk_cnt_reg < STK_LAST);
        st.out_free    = !out_valid_reg || !rsp_stall;
    end

    always_comb
    begin
        res_next       = res_reg;
        cnt_next       = cnt_reg;
        width_next     = width_reg;
        nfc_next       = nfc_reg;
        hwm_next       = hwm_reg;
        prev_next      = prev_reg;
        ac_next        = ac_reg;
        ended_next     = ended_reg;
        stk_cnt_next   = stk_cnt_reg;
        root_next      = root_reg;
        steps_next     = steps_reg;
        code_next      = code_reg;
        cur_next       = cur_reg;
        ent_valid_next = ent_valid_reg;
        resp_next      = resp_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_beat_next  = out_beat_reg;
        case (cmd)
            CMD_PUSH_BYTE:
            begin
                if (cnt_reg > RES_LIMIT)
                begin
                    resp_next = ST_REJECTED;
                end
                else
                begin
                    res_next  = res_reg | (24'(req_beat.data_byte) << cnt_reg);
                    cnt_next  = cnt_reg + 5'd8;
                    resp_next = ST_ACCEPTED;
                end
            end
            CMD_RESP_END:  resp_next = ST_END;
            CMD_RESP_NEED: resp_next = ST_NEED_BYTE;
            CMD_TAKE_CODE:
            begin
                res_next = res_reg >> width_reg;
                cnt_next = cnt_reg - {1'b0, width_reg};
                if (nfc_reg == {1'b0, code_mask} && width_reg < MAXW)
                begin
                    width_next = width_reg + 4'd1;
                end
                if (ac_reg)
                begin
                    ac_next   = 1'b0;
                    prev_next = code;
                    cur_next  = code;
                end
                else if (code == END_CODE)
                begin
                    ended_next = 1'b1;
                    resp_next  = ST_END;
                end
                else if (code == RESTART_CODE)
                begin
                    width_next = START_WIDTH;
                    nfc_next   = FIRST_FREE;
                    ac_next    = 1'b1;
                end
                else
                begin
                    root_next  = ({1'b0, code} == nfc_reg) ? prev_reg : code;
                    steps_next = '0;
                    code_next  = code;
                end
            end
            CMD_WALK_RD:
            begin
                ent_valid_next = is_entry(root_reg, hwm_reg);
            end
            CMD_WALK_STEP:
            begin
                root_next  = tbl_rd_reg.prefix;
                steps_next = steps_reg + SW'(1);
            end
            CMD_ADD:
            begin
                if (tbl_wr)
                begin
                    nfc_next = nfc_reg + 13'd1;
                    if (nfc_reg >= hwm_reg)
                    begin
                        hwm_next = nfc_reg + 13'd1;
                    end
                end
                prev_next = code_reg;
                cur_next  = code_reg;
            end
            CMD_STR_RD:
            begin
                ent_valid_next = is_entry(cur_reg, hwm_reg);
            end
            CMD_STR_WR:
            begin
                stk_cnt_next = stk_cnt_reg + 13'd1;
                cur_next     = tbl_rd_reg.prefix;
            end
            CMD_POP:
            begin
                stk_cnt_next = stk_cnt_reg - 13'd1;
                resp_next    = ST_PIXEL;
            end
            CMD_LOAD_OUT:
            begin
                out_valid_next       = 1'b1;
                out_beat_next.status = resp_reg;
                out_beat_next.pixel  = (resp_reg == ST_PIXEL) ? stk_rd_reg : 8'd0;
            end
            default:
            begin
                resp_next = resp_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg       <= '0;
            cnt_reg       <= '0;
            width_reg     <= START_WIDTH;
            nfc_reg       <= FIRST_FREE;
            hwm_reg       <= FIRST_FREE;
            prev_reg      <= '0;
            ac_reg        <= 1'b0;
            ended_reg     <= 1'b0;
            stk_cnt_reg   <= '0;
            ent_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            res_reg       <= res_next;
            cnt_reg       <= cnt_next;
            width_reg     <= width_next;
            nfc_reg       <= nfc_next;
            hwm_reg       <= hwm_next;
            prev_reg      <= prev_next;
            ac_reg        <= ac_next;
            ended_reg     <= ended_next;
            stk_cnt_reg   <= stk_cnt_next;
            ent_valid_reg <= ent_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg     <= root_next;
        steps_reg    <= steps_next;
        code_reg     <= code_next;
        cur_reg      <= cur_next;
        resp_reg     <= resp_next;
        out_beat_reg <= out_beat_next;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_wr)
        begin
            tbl_mem[nfc_reg[AW-1:0]] <= tbl_wdata;
        end
        if (cmd == CMD_WALK_RD || cmd == CMD_STR_RD)
        begin
            tbl_rd_reg <= tbl_mem[tbl_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_STR_WR)
        begin
            stack_mem[stk_cnt_reg[11:0]] <= str_char;
        end
        if (cmd == CMD_POP)
        begin
            stk_rd_reg <= stack_mem[12'(stk_cnt_reg - 13'd1)];
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_beat  = out_beat_reg;

    a_res_bits: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 5'd24)
        else $error("Bit reservoir count exceeds its width.");

    a_width: assert property (@(posedge clk) disable iff (!rst_n)
        width_reg >= START_WIDTH && width_reg <= MAXW)
        else $error("Code width out of range.");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        hwm_reg <= TD13 && nfc_reg <= TD13)
        else $error("Table fill mark passed the table depth.");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_POP |-> stk_cnt_reg != 13'd0)
        else $error("Pop from an empty string stack.");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_STR_WR |-> stk_cnt_reg <= STK_LAST)
        else $error("String stack overflow.");

endmodule

### bench/lzw_image_decoder_tb.sv
// Testbench for the LZW image decoder: generated code streams checked against a local decoder.
`timescale 1ns / 100ps

module lzw_image_decoder_tb;
    import lzwd_pkg::*;

    localparam int DEPTH     = 4096;
    localparam int NO_LINK   = 4096;
    localparam int CYCLE_CAP = 150000000;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_beat_t req_beat;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_beat_t rsp_beat;

    lzw_image_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_beat  (req_beat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_beat  (rsp_beat)
    );

    // Decoder state as predicted by the bench.
    logic [23:0] res_bits;
    int          res_cnt;
    int          cw;
    int          nfc;
    int          prev_code;
    bit          after_clr;
    bit          ended;
    int          prefix_mem [DEPTH];
    logic [7:0]  suffix_mem [DEPTH];
    logic [7:0]  stack_mem [DEPTH];
    int          sp;

    // Code stream generator state.
    int          gw;
    int          gnf;
    bit          gfirst;
    logic [31:0] pack_acc;
    int          pack_bits;
    logic [7:0]  byte_q [$];

    rsp_beat_t   pending_rsp [$];
    int          errors;
    int          items;
    int          checked;
    int          cycles;
    int          gap_pct;
    int          stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int link_of(int c);
        return (c < DEPTH) ? prefix_mem[c] : NO_LINK;
    endfunction

    function automatic logic [7:0] char_of(int c);
        return (c < DEPTH) ? suffix_mem[c] : c[7:0];
    endfunction

    task automatic decode_beat(input req_beat_t b, output rsp_beat_t r);
        logic [31:0] wide;
        int          code;
        int          root;
        int          steps;
        int          c;
        bit          done;
        r = '0;
        if (b.op == OP_PUSH)
        begin
            if (res_cnt > RES_LIMIT)
            begin
                r.status = ST_REJECTED;
            end
            else
            begin
                wide = {8'b0, res_bits} | (32'(b.data_byte) << res_cnt);
                res_bits = wide[23:0];
                res_cnt += 8;
                r.status = ST_ACCEPTED;
            end
            return;
        end
        done = 0;
        while (!done)
        begin
            if (sp > 0)
            begin
                sp--;
                r.status = ST_PIXEL;
                r.pixel = stack_mem[sp];
                done = 1;
            end
            else if (ended)
            begin
                r.status = ST_END;
                done = 1;
            end
            else if (res_cnt < cw)
            begin
                r.status = ST_NEED_BYTE;
                done = 1;
            end
            else
            begin
                code = int'(res_bits) & ((1 << cw) - 1);
                res_bits = res_bits >> cw;
                res_cnt -= cw;
                if (nfc == (1 << cw) - 1 && cw < 12)
                    cw++;
                if (after_clr)
                begin
                    after_clr = 0;
                end
                else if (code == int'(END_CODE))
                begin
                    ended = 1;
                    r.status = ST_END;
                    done = 1;
                end
                else if (code == int'(RESTART_CODE))
                begin
                    cw = START_WIDTH;
                    nfc = FIRST_FREE;
                    after_clr = 1;
                end
                else
                begin
                    root = (code == nfc) ? prev_code : code;
                    steps = 0;
                    while (link_of(root) != NO_LINK && steps < DEPTH)
                    begin
                        root = link_of(root);
                        steps++;
                    end
                    if (nfc < DEPTH)
                    begin
                        prefix_mem[nfc] = prev_code;
                        suffix_mem[nfc] = char_of(root);
                        nfc++;
                    end
                end
                // A clear code read outside the literal slot only rearms the decoder.
                if (!done && !(code == int'(RESTART_CODE) && after_clr))
                begin
                    prev_code = code;
                    c = code;
                    do
                    begin
                        stack_mem[sp] = char_of(c);
                        sp++;
                        c = link_of(c);
                    end
                    while (c != NO_LINK && sp < STACK_DEPTH);
                end
            end
        end
    endtask

    task automatic emit_code(input int c);
        pack_acc = pack_acc | (32'(c) << pack_bits);
        pack_bits += gw;
        while (pack_bits >= 8)
        begin
            byte_q.push_back(pack_acc[7:0]);
            pack_acc = pack_acc >> 8;
            pack_bits -= 8;
        end
        if (gnf == (1 << gw) - 1 && gw < 12)
            gw++;
        if (gfirst)
        begin
            gfirst = 0;
        end
        else if (c == int'(RESTART_CODE))
        begin
            gw = START_WIDTH;
            gnf = FIRST_FREE;
            gfirst = 1;
        end
        else if (c != int'(END_CODE) && gnf < DEPTH)
        begin
            gnf++;
        end
    endtask

    function automatic int pick_code(input int noise_pct);
        int hi;
        int c;
        if (gfirst)
            return $urandom_range(0, 255);
        if (($urandom % 100) < noise_pct)
        begin
            c = $urandom_range(0, (1 << gw) - 1);
            return (c == int'(END_CODE)) ? int'(RESTART_CODE) : c;
        end
        hi = (gnf > 4095) ? 4095 : gnf;
        if (($urandom % 2) == 0)
            return $urandom_range(0, 255);
        return $urandom_range(258, hi);
    endfunction

    task automatic send_beat(input logic op, input logic [7:0] data);
        req_beat_t b;
        rsp_beat_t r;
        b.op = op;
        b.data_byte = data;
        if (($urandom % 100) < gap_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_beat <= b;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        decode_beat(b, r);
        pending_rsp.push_back(r);
        items++;
    endtask

    // Interleave pushes of the queued bytes with pixel pulls until the decoder runs dry.
    task automatic drain_stream(input bit push_heavy);
        rsp_beat_t last;
        bit        quit;
        quit = 0;
        while (!quit)
        begin
            if (ended)
            begin
                quit = 1;
            end
            else if (byte_q.size() == 0 && sp == 0 && res_cnt < cw)
            begin
                if ($urandom % 2)
                    send_beat(OP_PULL, $urandom);
                quit = 1;
            end
            else if (byte_q.size() > 0 &&
                     ((sp == 0 && res_cnt < cw) || ($urandom % 4) == 0 || push_heavy))
            begin
                send_beat(OP_PUSH, byte_q[0]);
                last = pending_rsp[$];
                if (last.status == ST_ACCEPTED)
                    void'(byte_q.pop_front());
                if (push_heavy && last.status == ST_REJECTED)
                    send_beat(OP_PULL, $urandom);
            end
            else
            begin
                send_beat(OP_PULL, $urandom);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on result %0d: %s got %0d expected %0d", checked, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rsp_beat_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                report_mismatch("unexpected beat, status", rsp_beat.status, -1);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_beat.status !== want.status)
                    report_mismatch("status", rsp_beat.status, want.status);
                if (rsp_beat.pixel !== want.pixel)
                    report_mismatch("pixel", rsp_beat.pixel, want.pixel);
            end
            checked++;
        end
        rsp_stall <= (($urandom % 100) < stall_pct);
    end

    task automatic test_directed();
        int list [] = '{0, 255, 256, 257, 258, 255, 0, 259, 256, 0, 258, 511};
        send_beat(OP_PULL, 8'h00);
        foreach (list[i])
            emit_code(list[i]);
        drain_stream(1);
        repeat (4)
            emit_code($urandom_range(0, 255));
        repeat (4)
        begin
            send_beat(OP_PUSH, byte_q[0]);
            if (pending_rsp[$].status == ST_ACCEPTED)
                void'(byte_q.pop_front());
        end
        drain_stream(0);
        emit_code(RESTART_CODE);
        drain_stream(0);
    endtask

    task automatic test_streams(input int gap, input int stall, input int quota, input int longest);
        int stop;
        gap_pct = gap;
        stall_pct = stall;
        stop = items + quota;
        if (longest > 0)
        begin
            for (int i = 0; i < longest; i++)
                emit_code(gfirst ? $urandom_range(0, 255) :
                          (($urandom % 8) ? $urandom_range(0, 255) : pick_code(0)));
            drain_stream(0);
        end
        while (items < stop)
        begin
            if (($urandom % 3) == 0)
                emit_code(RESTART_CODE);
            repeat ($urandom_range(3, 40))
                emit_code(pick_code(($urandom % 5 == 0) ? 30 : 0));
            drain_stream(($urandom % 6) == 0);
        end
    endtask

    task automatic test_end_of_stream();
        emit_code(END_CODE);
        if (pack_bits > 0)
        begin
            byte_q.push_back(pack_acc[7:0]);
            pack_bits = 0;
        end
        while (byte_q.size() > 0)
        begin
            send_beat(OP_PUSH, byte_q[0]);
            if (pending_rsp[$].status == ST_ACCEPTED)
                void'(byte_q.pop_front());
            else
                send_beat(OP_PULL, 8'h00);
        end
        while (!ended)
            send_beat(OP_PULL, 8'h00);
        send_beat(OP_PULL, 8'h00);
        send_beat(OP_PUSH, 8'h3C);
        send_beat(OP_PULL, 8'hFF);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_beat = '0;
        rsp_stall = 1'b0;
        errors = 0;
        items = 0;
        checked = 0;
        cycles = 0;
        gap_pct = 0;
        stall_pct = 0;
        res_bits = '0;
        res_cnt = 0;
        cw = START_WIDTH;
        nfc = FIRST_FREE;
        prev_code = 0;
        after_clr = 0;
        ended = 0;
        sp = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            prefix_mem[i] = NO_LINK;
            suffix_mem[i] = i[7:0];
            stack_mem[i] = '0;
        end
        gw = START_WIDTH;
        gnf = FIRST_FREE;
        gfirst = 0;
        pack_acc = '0;
        pack_bits = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_streams(0, 0, 400, 270);
        test_streams(46, 0, 400, 0);
        test_streams(0, 46, 400, 0);
        test_streams(37, 37, 400, 0);
        test_end_of_stream();

        @(posedge clk);
        req_valid <= 1'b0;
        while (pending_rsp.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d beats and checked %0d results over four idling mixes,", items, checked);
        $display("covering clears, reused codes, rejected bytes, noise codes and stream end.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
hw/rtl/lzwd_pkg.sv
hw/rtl/lzwd_ctrl.sv
hw/rtl/lzwd_datapath.sv
hw/rtl/lzw_image_decoder.sv
bench/lzw_image_decoder_tb.sv
